// File: hw/rtl/acr_pkg.sv
// Shared constants, codes and control structs of the arithmetic coder renormalizer.
package acr_pkg;

   localparam int WORD_W            = 32;  // result word and bound port width
   localparam int CNT_W             = 6;   // bit count of one result word, 0..32
   localparam int PEND_W            = 8;   // pending underflow counter width
   localparam int PHASE_W           = 3;   // emitted bits modulo a byte
   localparam int BYTE_BITS         = 8;
   localparam int DEF_RANGE_WIDTH   = 32;
   localparam int DEF_PENDING_MAX   = 255;

   localparam logic CMD_PROCESS = 1'b0;
   localparam logic CMD_FLUSH   = 1'b1;

   // sequencer -> word packer
   typedef struct packed {
      logic bit_en;    // shift one bit into the word
      logic bit_val;
      logic push;      // move the word to the result register
      logic last;      // pushed word closes the item
   } pk_ctrl_type;

   // word packer -> sequencer
   typedef struct packed {
      logic full;      // word holds 32 bits
      logic out_free;  // result register can load this cycle
   } pk_stat_type;

endpackage

// File: hw/rtl/acr_word_pack.sv
// Bit accumulator and result register of the renormalizer.
module acr_word_pack
   import acr_pkg::*;
#(
   parameter int RANGE_WIDTH = DEF_RANGE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pk_ctrl_type            ctrl,
   output pk_stat_type            stat,
   input  logic [RANGE_WIDTH-1:0] bound_high,
   input  logic [RANGE_WIDTH-1:0] bound_low,
   input  logic                   saturated,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [WORD_W-1:0]      rsp_out_bits,
   output logic [CNT_W-1:0]       rsp_out_count,
   output logic [WORD_W-1:0]      rsp_new_high,
   output logic [WORD_W-1:0]      rsp_new_low,
   output logic                   rsp_pending_saturated,
   output logic                   rsp_last_chunk
);

   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              valid_ff, valid_in;
   logic [WORD_W-1:0] bits_ff, high_ff, low_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              sat_ff, last_ff;
   logic              load;

   assign stat.out_free = !valid_ff || !rsp_stall;
   assign stat.full     = (cnt_ff == CNT_W'(WORD_W));
   assign load          = ctrl.push && stat.out_free;

   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      if (load) begin
         acc_in = '0;
         cnt_in = '0;
      end else if (ctrl.bit_en) begin
         acc_in = {acc_ff[WORD_W-2:0], ctrl.bit_val};
         cnt_in = cnt_ff + 1'b1;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   // acc is cleared on reset too: partial words must read zero above the used bits
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bits_ff  <= acc_ff;
         count_ff <= cnt_ff;
         high_ff  <= WORD_W'(bound_high);
         low_ff   <= WORD_W'(bound_low);
         sat_ff   <= saturated;
         last_ff  <= ctrl.last;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_out_bits          = bits_ff;
   assign rsp_out_count         = count_ff;
   assign rsp_new_high          = high_ff;
   assign rsp_new_low           = low_ff;
   assign rsp_pending_saturated = sat_ff;
   assign rsp_last_chunk        = last_ff;

endmodule

// File: hw/rtl/arith_coder_renormalizer.sv
// Arithmetic-encoder range renormalizer: bound shifting, underflow tracking, bit output.
//
// One item at a time. A process item shifts both bounds one bit at a time:
// first each matching leading bit (k), then each removed underflow bit (u).
// A separate copy of the high bound then sends out the emitted bits one per
// cycle, unless a full word waits for the result register: the first bit,
// the pending bits (P, the count held before this item), and the other k-1
// bits. Each finished 32-bit word is pushed to the result register, and a
// final step loads the last word. A process item without matching top bits
// emits no bits. A flush item sends a one, then zeros up to the byte
// boundary. req_stall is high from acceptance until the last word of the
// item sits in the result register; that register lets the next item in
// while the last word waits on rsp_stall. Result words are right aligned:
// with out_count c the first bit is at bit c-1. new_high, new_low and
// pending_saturated are the same in every word of an item; a flush reports
// zero bounds and leaves the pending count alone.
module arith_coder_renormalizer
   import acr_pkg::*;
#(
   parameter int RANGE_WIDTH = DEF_RANGE_WIDTH,
   parameter int PENDING_MAX = DEF_PENDING_MAX
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_command,
   input  logic [WORD_W-1:0] req_range_high,
   input  logic [WORD_W-1:0] req_range_low,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WORD_W-1:0] rsp_out_bits,
   output logic [CNT_W-1:0]  rsp_out_count,
   output logic [WORD_W-1:0] rsp_new_high,
   output logic [WORD_W-1:0] rsp_new_low,
   output logic              rsp_pending_saturated,
   output logic              rsp_last_chunk
);

   localparam int W  = RANGE_WIDTH;
   localparam int KW = $clog2(RANGE_WIDTH + 1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SHIFT = 7'b0000010,   // strip matching leading bits
      ST_UFLOW = 7'b0000100,   // strip underflow run below the top bit
      ST_FIRST = 7'b0001000,   // first output bit
      ST_PEND  = 7'b0010000,   // pending bits, inverted
      ST_REST  = 7'b0100000,   // remaining k-1 bits
      ST_DONE  = 7'b1000000    // load final word
   } state_type;

   state_type          state_ff, state_in;
   logic [W-1:0]       hi_ff, hi_in, lo_ff, lo_in, src_ff, src_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [PEND_W-1:0]  pend_cnt_ff, pend_cnt_in;
   logic [PEND_W-1:0]  pending_ff, pending_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               first_ff, first_in;
   logic               uflow_hit, pend_at_max;
   pk_ctrl_type        pk_ctrl;
   pk_stat_type        pk_stat;

   assign uflow_hit   = hi_ff[W-1] && !lo_ff[W-1] && !hi_ff[W-2] && lo_ff[W-2];
   assign pend_at_max = (pending_ff == PEND_W'(PENDING_MAX));
   assign req_stall   = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      hi_in       = hi_ff;
      lo_in       = lo_ff;
      src_in      = src_ff;
      k_in        = k_ff;
      pend_cnt_in = pend_cnt_ff;
      pending_in  = pending_ff;
      first_in    = first_ff;
      pk_ctrl     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_FLUSH) begin
                  // a one, then zeros to the byte boundary
                  hi_in       = '0;
                  lo_in       = '0;
                  src_in      = {1'b1, {(W-1){1'b0}}};
                  k_in        = KW'(BYTE_BITS) - KW'(phase_ff);
                  pend_cnt_in = '0;
                  state_in    = ST_FIRST;
               end else begin
                  hi_in    = req_range_high[W-1:0];
                  lo_in    = req_range_low[W-1:0];
                  src_in   = req_range_high[W-1:0];
                  k_in     = '0;
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            // fill bits never match, so the run ends by itself at k = W
            if (hi_ff[W-1] == lo_ff[W-1]) begin
               hi_in = {hi_ff[W-2:0], 1'b1};
               lo_in = {lo_ff[W-2:0], 1'b0};
               k_in  = k_ff + 1'b1;
            end else begin
               if (k_ff != '0) begin
                  pend_cnt_in = pending_ff;
                  pending_in  = '0;
               end
               state_in = ST_UFLOW;
            end
         end
         ST_UFLOW: begin
            if (uflow_hit) begin
               hi_in = {1'b1, hi_ff[W-3:0], 1'b1};
               lo_in = {1'b0, lo_ff[W-3:0], 1'b0};
               if (!pend_at_max) begin
                  pending_in = pending_ff + 1'b1;
               end
            end else begin
               state_in = (k_ff != '0) ? ST_FIRST : ST_DONE;
            end
         end
         ST_FIRST: begin
            // word is empty here: the previous item's last word has left
            pk_ctrl.bit_en  = 1'b1;
            pk_ctrl.bit_val = src_ff[W-1];
            first_in        = src_ff[W-1];
            src_in          = {src_ff[W-2:0], 1'b0};
            state_in        = ST_PEND;
         end
         ST_PEND: begin
            if (pend_cnt_ff == '0) begin
               state_in = ST_REST;
            end else if (pk_stat.full) begin
               pk_ctrl.push = 1'b1;
            end else begin
               pk_ctrl.bit_en  = 1'b1;
               pk_ctrl.bit_val = !first_ff;
               pend_cnt_in     = pend_cnt_ff - 1'b1;
            end
         end
         ST_REST: begin
            if (k_ff[KW-1:1] == '0) begin
               state_in = ST_DONE;
            end else if (pk_stat.full) begin
               pk_ctrl.push = 1'b1;
            end else begin
               pk_ctrl.bit_en  = 1'b1;
               pk_ctrl.bit_val = src_ff[W-1];
               src_in          = {src_ff[W-2:0], 1'b0};
               k_in            = k_ff - 1'b1;
            end
         end
         ST_DONE: begin
            pk_ctrl.push = 1'b1;
            pk_ctrl.last = 1'b1;
            if (pk_stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign phase_in = pk_ctrl.bit_en ? phase_ff + 1'b1 : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pending_ff <= '0;
         phase_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         phase_ff   <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      src_ff      <= src_in;
      k_ff        <= k_in;
      pend_cnt_ff <= pend_cnt_in;
      first_ff    <= first_in;
   end

   acr_word_pack #(
      .RANGE_WIDTH (RANGE_WIDTH)
   ) u_pack (
      .clock                 (clock),
      .reset                 (reset),
      .ctrl                  (pk_ctrl),
      .stat                  (pk_stat),
      .bound_high            (hi_ff),
      .bound_low             (lo_ff),
      .saturated             (pend_at_max),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_bits          (rsp_out_bits),
      .rsp_out_count         (rsp_out_count),
      .rsp_new_high          (rsp_new_high),
      .rsp_new_low           (rsp_new_low),
      .rsp_pending_saturated (rsp_pending_saturated),
      .rsp_last_chunk        (rsp_last_chunk)
   );

   // only the closing word of an item may be short
   a_short_word_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_chunk) |-> (rsp_out_count == CNT_W'(WORD_W)))
      else $error("non-final result word is not full");

   // pending count stays within its limit
   a_pending_limit: assert property (@(posedge clock) disable iff (reset)
      (pending_ff <= PEND_W'(PENDING_MAX)))
      else $error("pending underflow count above limit");

   // leading-bit count never runs past the bound width
   a_k_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (k_ff <= KW'(RANGE_WIDTH)))
      else $error("matching bit count above range width");

   // a bit is never shifted into a full word
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      pk_stat.full |-> !pk_ctrl.bit_en)
      else $error("bit emitted into a full word");

endmodule
